// ===== hdl/urelay_pkg.sv =====
// ----------------------------------------------------------------------------
// urelay_pkg
// Shared types, register map and helpers for the two-line serial relay.
// ----------------------------------------------------------------------------
package urelay_pkg;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned ByteW   = 8;

  localparam logic [CfgW-1:0] BitPeriodRst        = 16'd833;
  localparam logic [CfgW-1:0] FirstSampleDelayRst = 16'd1249;
  localparam logic [CfgW-1:0] SamplePeriodRst     = 16'd810;

  typedef enum logic [1:0] {
    REG_BIT_PERIOD         = 2'd0,
    REG_FIRST_SAMPLE_DELAY = 2'd1,
    REG_SAMPLE_PERIOD      = 2'd2,
    REG_UNUSED             = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RX   = 2'd1,
    MODE_TX   = 2'd2
  } relay_mode_e;

  typedef struct packed {
    logic [CfgW-1:0] bit_period;
    logic [CfgW-1:0] first_sample_delay;
    logic [CfgW-1:0] sample_period;
  } relay_cfg_t;

  // A programmed count of zero behaves as a single tick.
  function automatic logic [CfgW-1:0] cnt_load(input logic [CfgW-1:0] v);
    cnt_load = (v == '0) ? CfgW'(1) : v;
  endfunction

endpackage

// ===== hdl/urelay_if.sv =====
// ----------------------------------------------------------------------------
// urelay_if
// Valid/ready channels carrying line samples in and relay results out.
// ----------------------------------------------------------------------------
interface urelay_in_if;
  logic valid;
  logic ready;
  logic terminal_line_in;
  logic device_line_in;

  modport source (output valid, output terminal_line_in, output device_line_in,
                  input ready);
  modport sink (input valid, input terminal_line_in, input device_line_in,
                output ready);
endinterface

interface urelay_out_if;
  logic       valid;
  logic       ready;
  logic       terminal_line_out;
  logic       device_line_out;
  logic [7:0] relayed_byte;
  logic       byte_done;
  logic       direction;

  modport source (output valid, output terminal_line_out, output device_line_out,
                  output relayed_byte, output byte_done, output direction,
                  input ready);
  modport sink (input valid, input terminal_line_out, input device_line_out,
                input relayed_byte, input byte_done, input direction,
                output ready);
endinterface

// ===== hdl/urelay_apb_regs.sv =====
// ----------------------------------------------------------------------------
// urelay_apb_regs
// APB register file holding the bit timing configuration.
// ----------------------------------------------------------------------------
module urelay_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [urelay_pkg::AddrW-1:0]  paddr,
  input  logic [urelay_pkg::DataW-1:0]  pwdata,
  output logic [urelay_pkg::DataW-1:0]  prdata,
  output logic                          pready,
  output urelay_pkg::relay_cfg_t        cfg_o
);
  import urelay_pkg::*;

  relay_cfg_t cfg_q, cfg_d;
  reg_idx_e   idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_BIT_PERIOD:         cfg_d.bit_period         = pwdata[CfgW-1:0];
        REG_FIRST_SAMPLE_DELAY: cfg_d.first_sample_delay = pwdata[CfgW-1:0];
        REG_SAMPLE_PERIOD:      cfg_d.sample_period      = pwdata[CfgW-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BIT_PERIOD:         prdata = DataW'(cfg_q.bit_period);
      REG_FIRST_SAMPLE_DELAY: prdata = DataW'(cfg_q.first_sample_delay);
      REG_SAMPLE_PERIOD:      prdata = DataW'(cfg_q.sample_period);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_period         <= BitPeriodRst;
      cfg_q.first_sample_delay <= FirstSampleDelayRst;
      cfg_q.sample_period      <= SamplePeriodRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/urelay_core.sv =====
// ----------------------------------------------------------------------------
// urelay_core
// Receive/transmit sequencer with its result register and handshake.
// ----------------------------------------------------------------------------
module urelay_core #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  urelay_pkg::relay_cfg_t cfg_i,
  urelay_in_if.sink              in_i,
  urelay_out_if.source           out_o
);
  import urelay_pkg::*;

  localparam int unsigned IdxW = $clog2(DATA_BITS + 4);

  relay_mode_e           mode_q, mode_d;
  logic [CfgW-1:0]       tick_q, tick_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [DATA_BITS-1:0]  shift_q, shift_d;
  logic [1:0]            lines_q, lines_d;
  logic                  dir_q, dir_d;

  logic                  res_vld_q;
  logic                  res_term_q, res_dev_q, res_done_q, res_dir_q;
  logic [ByteW-1:0]      res_byte_q;

  logic                  in_fire;
  logic                  done;
  logic [ByteW-1:0]      byte_out;
  logic [IdxW-1:0]       idx_inc;
  logic                  rx_bit;
  logic                  slot_lvl;
  logic                  drive_en;
  logic                  drive_lvl;
  logic [DATA_BITS+ByteW-1:0] shift_ext;

  assign in_i.ready = !res_vld_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign idx_inc    = idx_q + IdxW'(1);
  assign rx_bit     = dir_q ? in_i.device_line_in : in_i.terminal_line_in;
  assign shift_ext  = {{ByteW{1'b0}}, shift_d};

  // Level of the transmit slot about to start: idle-high, start, data, stop.
  always_comb begin
    slot_lvl = 1'b1;
    if (idx_inc == IdxW'(1)) begin
      slot_lvl = 1'b0;
    end
    for (int unsigned i = 0; i < DATA_BITS; i++) begin
      if (idx_inc == IdxW'(i + 2)) begin
        slot_lvl = shift_q[i];
      end
    end
  end

  always_comb begin
    mode_d    = mode_q;
    tick_d    = tick_q;
    idx_d     = idx_q;
    shift_d   = shift_q;
    dir_d     = dir_q;
    done      = 1'b0;
    drive_en  = 1'b0;
    drive_lvl = 1'b1;
    unique case (mode_q)
      MODE_IDLE: begin
        if (!in_i.terminal_line_in || !in_i.device_line_in) begin
          dir_d   = in_i.terminal_line_in;
          mode_d  = MODE_RX;
          tick_d  = cnt_load(cfg_i.first_sample_delay);
          idx_d   = '0;
          shift_d = '0;
        end
      end
      MODE_RX: begin
        if (tick_q > CfgW'(1)) begin
          tick_d = tick_q - CfgW'(1);
        end else begin
          shift_d = {rx_bit, shift_q[DATA_BITS-1:1]};
          if (idx_inc >= IdxW'(DATA_BITS)) begin
            done      = 1'b1;
            mode_d    = MODE_TX;
            idx_d     = '0;
            tick_d    = cnt_load(cfg_i.bit_period);
            drive_en  = 1'b1;
            drive_lvl = 1'b1;
          end else begin
            idx_d  = idx_inc;
            tick_d = cnt_load(cfg_i.sample_period);
          end
        end
      end
      MODE_TX: begin
        if (tick_q > CfgW'(1)) begin
          tick_d = tick_q - CfgW'(1);
        end else if (idx_inc > IdxW'(DATA_BITS + 2)) begin
          mode_d    = MODE_IDLE;
          idx_d     = '0;
          tick_d    = '0;
          drive_en  = 1'b1;
          drive_lvl = 1'b1;
        end else begin
          idx_d     = idx_inc;
          tick_d    = cnt_load(cfg_i.bit_period);
          drive_en  = 1'b1;
          drive_lvl = slot_lvl;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase

    // Bit 0 is the terminal line, bit 1 the device line; drive the far side.
    lines_d = lines_q;
    if (drive_en) begin
      if (dir_q) begin
        lines_d[0] = drive_lvl;
      end else begin
        lines_d[1] = drive_lvl;
      end
    end
    byte_out = done ? shift_ext[ByteW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      tick_q  <= '0;
      idx_q   <= '0;
      shift_q <= '0;
      lines_q <= 2'b11;
      dir_q   <= 1'b0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      tick_q  <= tick_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      lines_q <= lines_d;
      dir_q   <= dir_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      res_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_term_q <= lines_d[0];
      res_dev_q  <= lines_d[1];
      res_byte_q <= byte_out;
      res_done_q <= done;
      res_dir_q  <= dir_d;
    end
  end

  assign out_o.valid             = res_vld_q;
  assign out_o.terminal_line_out = res_term_q;
  assign out_o.device_line_out   = res_dev_q;
  assign out_o.relayed_byte      = res_byte_q;
  assign out_o.byte_done         = res_done_q;
  assign out_o.direction         = res_dir_q;

endmodule

// ===== hdl/uart_8n1_two_line_relay_unit.sv =====
// ----------------------------------------------------------------------------
// uart_8n1_two_line_relay_unit
// Half-duplex relay that receives an 8N1 byte on one serial line and resends
// it on the other, one time tick per input word.
// ----------------------------------------------------------------------------
// Each input word is one tick of the bit clock and carries the levels of both
// incoming lines; each accepted word yields exactly one result word with the
// two outgoing line levels, the direction, and the received byte on the tick
// the last data bit is sampled. The block takes one word per clock cycle:
// the sequencer update and the result are formed in a single pass of logic
// from the accepted word into the result register, and a new word is taken
// whenever that register is empty or is being emptied in the same cycle, so
// each result is registered from its word; output back-pressure stalls the input
// only for as long as the result register stays full. While idle, a low on
// the terminal line starts a reception, failing that a low on the device
// line; the terminal wins. Reception waits first_sample_delay ticks, then
// samples DATA_BITS bits LSB first every sample_period ticks, and the byte is
// sent on the other line as an idle-high slot, a start bit, the data bits and
// a stop bit, each bit_period ticks long. A timing register programmed to
// zero behaves as one tick. The three timing registers sit on an APB port at
// byte addresses 0, 4 and 8 and should be written only while the relay is
// idle.
// ----------------------------------------------------------------------------
module uart_8n1_two_line_relay_unit #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [urelay_pkg::AddrW-1:0]  paddr,
  input  logic [urelay_pkg::DataW-1:0]  pwdata,
  output logic [urelay_pkg::DataW-1:0]  prdata,
  output logic                          pready,
  urelay_in_if.sink                     in_i,
  urelay_out_if.source                  out_o
);
  import urelay_pkg::*;

  relay_cfg_t cfg;

  // Timing registers.
  urelay_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Receive and transmit sequencer with the result register.
  urelay_core #(
    .DATA_BITS (DATA_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
